### rtl/rcfp_pkg.sv
// ----------------------------------------------------------------------------
// rcfp_pkg: RGB command frame parser shared definitions
// Frame byte codes, phase and event encodings, and the result item layout.
// ----------------------------------------------------------------------------
`default_nettype none

package rcfp_pkg;

  localparam logic [7:0] HdrColor      = 8'hA0;
  localparam logic [7:0] HdrTimeout    = 8'hA1;
  localparam logic [7:0] FrameTail     = 8'hC0;
  localparam logic [7:0] HandshakeByte = 8'h76;  // 'v'

  localparam logic [4:0] DefaultTimeoutReset = 5'd5;
  localparam logic [4:0] MaxTimeoutReset     = 5'd20;

  // configuration register indexes
  localparam logic CfgDefaultTimeout = 1'b0;
  localparam logic CfgMaxTimeout     = 1'b1;

  typedef enum logic [7:0] {
    PH_IDLE  = 8'b0000_0001,
    PH_HEAD  = 8'b0000_0010,
    PH_RED   = 8'b0000_0100,
    PH_GREEN = 8'b0000_1000,
    PH_BLUE  = 8'b0001_0000,
    PH_CTAIL = 8'b0010_0000,
    PH_TVAL  = 8'b0100_0000,
    PH_TTAIL = 8'b1000_0000
  } phase_e;

  typedef enum logic [2:0] {
    EV_COLOR     = 3'd0,
    EV_HANDSHAKE = 3'd1,
    EV_RESET     = 3'd2,
    EV_RANGE     = 3'd3,
    EV_CONFIRM   = 3'd4
  } event_e;

  // packed MSB first: event_code lands in the lowest bits
  typedef struct packed {
    logic [4:0] timeout_now;
    logic [7:0] blue_level;
    logic [7:0] green_level;
    logic [7:0] red_level;
    event_e     event_code;
  } result_t;

endpackage

`default_nettype wire

### rtl/rgb_command_frame_parser_top.sv
// ----------------------------------------------------------------------------
// rgb_command_frame_parser_top: serial RGB command frame parser
// Output: a result item goes into the output buffer's head register, or first its skid slot, before m_axis.
// Throughput: one item per cycle while s_axis_tready_o is high; the parser state updates in one pass.
// s_axis_tready_o falls only when both output slots hold unread results.
// Reset: asynchronous, active low; idle phase, timeout 5, registers at 5/20.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_command_frame_parser_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  // input items
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  wire         s_axis_tuser_i,   // [0] command: 0 byte, 1 tick
  // result items
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [2:0] event_code, [10:3] red_level,
                                        // [18:11] green_level,
                                        // [26:19] blue_level, [31:27] timeout_now
  // configuration writes
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire         cfg_index_i,      // 0 default_timeout, 1 max_timeout
  input  wire  [4:0]  cfg_data_i
);
  import rcfp_pkg::*;

  logic [4:0] default_timeout_q;
  logic [4:0] max_timeout_q;
  logic       s_accept;
  logic       res_valid;
  result_t    res;
  result_t    out_data;

  // config writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_timeout_q <= DefaultTimeoutReset;
      max_timeout_q     <= MaxTimeoutReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgDefaultTimeout: default_timeout_q <= cfg_data_i;
        CfgMaxTimeout:     max_timeout_q     <= cfg_data_i;
        default:           ;
      endcase
    end
  end

  assign s_accept = s_axis_tvalid_i & s_axis_tready_o;

  // parser: state plus the result of the accepted item
  rcfp_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (s_accept),
    .command_i         (s_axis_tuser_i),
    .rx_byte_i         (s_axis_tdata_i),
    .default_timeout_i (default_timeout_q),
    .max_timeout_i     (max_timeout_q),
    .res_valid_o       (res_valid),
    .res_o             (res)
  );

  // result register with skid slot parts the two sides
  rcfp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .ready_o     (s_axis_tready_o),
    .valid_o     (m_axis_tvalid_o),
    .pop_ready_i (m_axis_tready_i),
    .data_o      (out_data)
  );

  assign m_axis_tdata_o = out_data;

  // only a color set event carries color levels
  a_rgb_only_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_data.event_code != EV_COLOR) |->
      (out_data.red_level == 8'd0 && out_data.green_level == 8'd0 &&
       out_data.blue_level == 8'd0))
    else $error("non-color event carries color levels");

  // input backpressure only follows a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> $past(m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled without a stalled result");

  // a full buffer drains one slot on a pop and reopens the input
  a_reopen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!s_axis_tready_o && m_axis_tready_i) |=> (s_axis_tready_o && m_axis_tvalid_o))
    else $error("buffer did not reopen after pop");

endmodule

`default_nettype wire

### rtl/rcfp_core.sv
// ----------------------------------------------------------------------------
// rcfp_core: frame parser state and next-state logic
// Updates phase, tick count, color holds and timeout on each accepted item
// and forms the result item, if any, in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rcfp_core (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   accept_i,
  input  wire                   command_i,
  input  wire  [7:0]            rx_byte_i,
  input  wire  [4:0]            default_timeout_i,
  input  wire  [4:0]            max_timeout_i,
  output logic                  res_valid_o,
  output rcfp_pkg::result_t     res_o
);
  import rcfp_pkg::*;

  phase_e     phase_q, phase_d;
  logic [4:0] tick_q, tick_d;
  logic [7:0] red_q, red_d, green_q, green_d, blue_q, blue_d;
  logic [4:0] limit_q, limit_d;

  always_comb begin
    logic [5:0] next_tick;
    logic       emit;
    logic       with_color;
    event_e     ev;

    phase_d    = phase_q;
    tick_d     = tick_q;
    red_d      = red_q;
    green_d    = green_q;
    blue_d     = blue_q;
    limit_d    = limit_q;
    emit       = 1'b0;
    with_color = 1'b0;
    ev         = EV_RESET;
    next_tick  = {1'b0, tick_q} + 6'd1;

    if (command_i) begin
      // timer tick
      if (phase_q != PH_IDLE) begin
        if (next_tick >= {1'b0, limit_q}) begin
          if (phase_q == PH_TTAIL) limit_d = default_timeout_i;
          phase_d = PH_IDLE;
          tick_d  = 5'd0;
          emit    = 1'b1;
          ev      = EV_RESET;
        end else begin
          tick_d = next_tick[5] ? 5'd31 : next_tick[4:0];
        end
      end
    end else begin
      unique case (phase_q) inside
        PH_IDLE, PH_HEAD: begin
          if (phase_q == PH_IDLE) tick_d = 5'd0;
          if (rx_byte_i == HdrColor) begin
            phase_d = PH_RED;
            tick_d  = 5'd0;
          end else if (rx_byte_i == HandshakeByte) begin
            phase_d = PH_IDLE;
            tick_d  = 5'd0;
            emit    = 1'b1;
            ev      = EV_HANDSHAKE;
          end else if (rx_byte_i == HdrTimeout) begin
            phase_d = PH_TVAL;
            tick_d  = 5'd0;
          end else begin
            // unknown header: wait, count keeps running
            phase_d = PH_HEAD;
          end
        end
        PH_RED: begin
          red_d   = rx_byte_i;
          tick_d  = 5'd0;
          phase_d = PH_GREEN;
        end
        PH_GREEN: begin
          green_d = rx_byte_i;
          tick_d  = 5'd0;
          phase_d = PH_BLUE;
        end
        PH_BLUE: begin
          blue_d  = rx_byte_i;
          tick_d  = 5'd0;
          phase_d = PH_CTAIL;
        end
        PH_CTAIL: begin
          if (rx_byte_i == FrameTail) begin
            tick_d     = 5'd0;
            phase_d    = PH_IDLE;
            emit       = 1'b1;
            with_color = 1'b1;
            ev         = EV_COLOR;
          end
        end
        PH_TVAL: begin
          tick_d = 5'd0;
          if (rx_byte_i != 8'd0 && rx_byte_i <= {3'd0, max_timeout_i}) begin
            limit_d = rx_byte_i[4:0];
            phase_d = PH_TTAIL;
          end else begin
            phase_d = PH_IDLE;
            emit    = 1'b1;
            ev      = EV_RANGE;
          end
        end
        PH_TTAIL: begin
          if (rx_byte_i == FrameTail) begin
            tick_d  = 5'd0;
            phase_d = PH_IDLE;
            emit    = 1'b1;
            ev      = EV_CONFIRM;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end

    res_valid_o       = accept_i & emit;
    res_o.event_code  = ev;
    res_o.red_level   = with_color ? red_q   : 8'd0;
    res_o.green_level = with_color ? green_q : 8'd0;
    res_o.blue_level  = with_color ? blue_q  : 8'd0;
    res_o.timeout_now = limit_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= 5'd0;
      red_q   <= 8'd0;
      green_q <= 8'd0;
      blue_q  <= 8'd0;
      limit_q <= DefaultTimeoutReset;
    end else if (accept_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      limit_q <= limit_d;
    end
  end

endmodule

`default_nettype wire

### rtl/rcfp_out_buf.sv
// ----------------------------------------------------------------------------
// rcfp_out_buf: two-entry output register with skid slot
// Holds result items until the downstream side takes them; ready is
// registered and drops only when both slots are full.
// ----------------------------------------------------------------------------
`default_nettype none

module rcfp_out_buf (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_i,
  input  rcfp_pkg::result_t     push_data_i,
  output logic                  ready_o,
  output logic                  valid_o,
  input  wire                   pop_ready_i,
  output rcfp_pkg::result_t     data_o
);
  import rcfp_pkg::*;

  result_t    head_q, skid_q;
  logic [1:0] count_q;
  logic       pop;

  assign pop     = valid_o & pop_ready_i;
  assign valid_o = count_q != 2'd0;
  assign ready_o = count_q != 2'd2;
  assign data_o  = head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      case ({push_i, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (count_q == 2'd2) begin
      if (pop) head_q <= skid_q;
    end else if (push_i) begin
      if (count_q == 2'd0 || pop) head_q <= push_data_i;
      else                        skid_q <= push_data_i;
    end
  end

endmodule

`default_nettype wire
